[hdl/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the preemptive priority scheduler: command
// codes, the task table entry and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

	localparam int unsigned SCHED_SLOTS = 16;

	localparam logic [15:0] TIME_MAX = 16'hFFFF;
	localparam logic [31:0] SUM_MAX  = 32'hFFFF_FFFF;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic [15:0] arrival;
		logic [7:0]  prio;
		logic [15:0] remaining;
		logic [15:0] burst;
	} pps_task_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} pps_state_t;

endpackage

`default_nettype wire

[hdl/pps_task_ram.sv]
// ----------------------------------------------------------------------------
// pps_task_ram
// Task table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_task_ram #(
	parameter int unsigned SLOTS = 16,
	parameter int unsigned AW    = 4
) (
	input  wire                  clk,
	input  wire                  we,
	input  wire [AW-1:0]         waddr,
	input  pps_pkg::pps_task_t   wdata,
	input  wire                  re,
	input  wire [AW-1:0]         raddr,
	output pps_pkg::pps_task_t   rdata
);
	import pps_pkg::*;

	pps_task_t mem [SLOTS];
	pps_task_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hdl/preemptive_priority_scheduler.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Unit-time preemptive priority scheduler over a table of tasks.
// ----------------------------------------------------------------------------
// An add item (cmd 0) stores a task in the next free slot and gives no
// result; it is dropped if the table is full or its burst is zero.
// A tick item (cmd 1) scans the loaded slots one per cycle through the single
// read port of the task table, picks the eligible task with the smallest
// priority (earlier arrival, then lower slot, on ties), advances time by one
// (saturating at TIME_MAX) and runs that task one unit, if there is one. The
// tick goes from the scan state, where the registered read data is compared,
// to the update state, which writes the result registers once the result
// register is not held by out_stall. The next item is accepted in the cycle
// after the previous tick has written its result, even while that result is not yet taken.
`default_nettype none

module preemptive_priority_scheduler #(
	parameter int unsigned TASK_SLOTS = pps_pkg::SCHED_SLOTS
) (
	input  wire         clk,
	input  wire         arst_n,
	// input channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         cmd,
	input  wire  [15:0] arrival_time,
	input  wire  [15:0] burst_length,
	input  wire  [7:0]  priority_level,
	// result channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic [15:0] time_after,
	output logic        ran_valid,
	output logic [3:0]  ran_slot,
	output logic        finished,
	output logic [15:0] completion_time,
	output logic [15:0] turnaround,
	output logic [15:0] waiting,
	output logic        all_done,
	output logic [31:0] total_turnaround,
	output logic [31:0] total_waiting
);
	import pps_pkg::*;

	localparam int unsigned SW = $clog2(TASK_SLOTS);
	localparam int unsigned LW = $clog2(TASK_SLOTS + 1);

	pps_state_t state_q, state_nx;

	logic [LW-1:0] loaded_q, done_q, rd_idx_q, done_nx;
	logic [15:0]   now_q, now_nx;
	logic [31:0]   sum_tat_q, sum_wt_q, sum_tat_nx, sum_wt_nx;
	logic          rd_vld_s1, found_q, out_valid_q;
	logic [SW-1:0] idx_s1, best_slot_q;
	pps_task_t     best_q, rd_task, wr_task;

	logic add_we, tick_go, rd_issue, scan_end, commit;
	logic cand_elig, cand_better;
	logic ram_we;
	logic [SW-1:0] ram_waddr;

	logic [15:0] rem_nx, tat, wt;
	logic        fin;
	logic [32:0] tat_sum_w, wt_sum_w;

	// ---------------- control ----------------
	always_comb begin
		add_we   = 1'b0;
		tick_go  = 1'b0;
		rd_issue = 1'b0;
		scan_end = 1'b0;
		commit   = 1'b0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				add_we  = in_valid && (cmd == CMD_ADD) && (loaded_q < LW'(TASK_SLOTS))
					&& (burst_length != 16'd0);
				tick_go = in_valid && (cmd == CMD_TICK);
			end
			ST_SCAN: begin
				rd_issue = (rd_idx_q < loaded_q);
				scan_end = !rd_issue && !rd_vld_s1;
			end
			ST_UPDATE: begin
				commit = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:   if (tick_go)  state_nx = ST_SCAN;
			ST_SCAN:   if (scan_end) state_nx = ST_UPDATE;
			ST_UPDATE: if (commit)   state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// ---------------- task table ----------------
	always_comb begin
		wr_task           = best_q;
		wr_task.remaining = rem_nx;
		ram_we            = add_we || (commit && found_q);
		ram_waddr         = best_slot_q;
		if (add_we) begin
			wr_task.arrival   = arrival_time;
			wr_task.prio      = priority_level;
			wr_task.remaining = burst_length;
			wr_task.burst     = burst_length;
			ram_waddr         = loaded_q[SW-1:0];
		end
	end

	pps_task_ram #(
		.SLOTS (TASK_SLOTS),
		.AW    (SW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_task),
		.re    (rd_issue),
		.raddr (rd_idx_q[SW-1:0]),
		.rdata (rd_task)
	);

	// ---------------- scan compare ----------------
	always_comb begin
		cand_elig   = (rd_task.arrival <= now_q) && (rd_task.remaining != 16'd0);
		cand_better = cand_elig && (!found_q || (rd_task.prio < best_q.prio) ||
			((rd_task.prio == best_q.prio) && (rd_task.arrival < best_q.arrival)));
	end

	// ---------------- tick update ----------------
	always_comb begin
		now_nx    = (now_q == TIME_MAX) ? now_q : now_q + 16'd1;
		rem_nx    = best_q.remaining - 16'd1;
		fin       = found_q && (rem_nx == 16'd0);
		tat       = now_nx - best_q.arrival;
		// negative only after time saturated
		wt        = (tat >= best_q.burst) ? tat - best_q.burst : 16'd0;
		tat_sum_w = {1'b0, sum_tat_q} + {17'd0, tat};
		wt_sum_w  = {1'b0, sum_wt_q} + {17'd0, wt};
		sum_tat_nx = sum_tat_q;
		sum_wt_nx  = sum_wt_q;
		if (fin) begin
			sum_tat_nx = tat_sum_w[32] ? SUM_MAX : tat_sum_w[31:0];
			sum_wt_nx  = wt_sum_w[32] ? SUM_MAX : wt_sum_w[31:0];
		end
		done_nx = done_q + LW'(fin);
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			loaded_q    <= '0;
			done_q      <= '0;
			now_q       <= '0;
			sum_tat_q   <= '0;
			sum_wt_q    <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (add_we) begin
				loaded_q <= loaded_q + LW'(1);
			end
			if (tick_go) begin
				rd_idx_q  <= '0;
				rd_vld_s1 <= 1'b0;
				found_q   <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				rd_vld_s1 <= rd_issue;
				if (rd_issue) begin
					rd_idx_q <= rd_idx_q + LW'(1);
				end
				if (rd_vld_s1 && cand_better) begin
					found_q <= 1'b1;
				end
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				now_q       <= now_nx;
				done_q      <= done_nx;
				sum_tat_q   <= sum_tat_nx;
				sum_wt_q    <= sum_wt_nx;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			idx_s1 <= rd_idx_q[SW-1:0];
			if (rd_vld_s1 && cand_better) begin
				best_q      <= rd_task;
				best_slot_q <= idx_s1;
			end
		end
		if (commit) begin
			time_after       <= now_nx;
			ran_valid        <= found_q;
			ran_slot         <= found_q ? 4'(best_slot_q) : 4'd0;
			finished         <= fin;
			completion_time  <= fin ? now_nx : 16'd0;
			turnaround       <= fin ? tat : 16'd0;
			waiting          <= fin ? wt : 16'd0;
			all_done         <= (done_nx == loaded_q);
			total_turnaround <= sum_tat_nx;
			total_waiting    <= sum_wt_nx;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[tb/preemptive_priority_scheduler_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_test
// Self-checking bench for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
// A short directed table covers the empty table, dropped adds, preemption,
// tie breaks and the field extremes. The random part then loads and ticks
// tasks with random arrivals, bursts and priorities, with noise adds that
// get dropped. Every tick is checked field by field against its directed
// row's result if given, else against a behavioral scheduler in the bench.

module preemptive_priority_scheduler_test;

	import pps_pkg::*;

	localparam int SLOTS        = SCHED_SLOTS;
	localparam int RAND_ITEMS   = 530;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam logic [15:0] BASE_TIME = 16'd2;

	typedef struct packed {
		logic        cmd;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
	} sched_item_t;

	typedef struct packed {
		logic [15:0] t_after;
		logic        ran;
		logic [3:0]  slot;
		logic        fin;
		logic [15:0] ct;
		logic [15:0] tat;
		logic [15:0] wt;
		logic        all_done;
		logic [31:0] tot_tat;
		logic [31:0] tot_wt;
	} tick_result_t;

	typedef struct packed {
		sched_item_t  item;
		logic [16:0]  reps;
		logic         typed;
		tick_result_t want;
	} dir_row_t;

	localparam sched_item_t  TICK_ITEM = '{CMD_TICK, 16'd0, 16'd0, 8'd0};
	localparam tick_result_t NO_RES    = '0;
	localparam tick_result_t EMPTY_T1  =
		'{16'd1, 1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1, 32'd0, 32'd0};
	localparam tick_result_t EMPTY_T2  =
		'{16'd2, 1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1, 32'd0, 32'd0};
	// task at arrival 0 with burst 1 runs on the first tick after the idle ones
	localparam tick_result_t FIRST_DONE =
		'{BASE_TIME + 16'd1, 1'b1, 4'd0, 1'b1, BASE_TIME + 16'd1, BASE_TIME + 16'd1,
		  BASE_TIME, 1'b1, 32'(BASE_TIME) + 32'd1, 32'(BASE_TIME)};

	localparam int NUM_ROWS = 14;
	localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
		'{TICK_ITEM, 17'd1, 1'b1, EMPTY_T1},
		'{'{CMD_ADD, 16'd0, 16'd0, 8'd0}, 17'd1, 1'b0, NO_RES},	// zero burst
		'{TICK_ITEM, 17'd1, 1'b1, EMPTY_T2},
		'{'{CMD_ADD, 16'd0, 16'd1, 8'd0}, 17'd1, 1'b0, NO_RES},
		'{TICK_ITEM, 17'd1, 1'b1, FIRST_DONE},
		'{'{CMD_ADD, BASE_TIME + 16'd1, 16'd2, 8'd255}, 17'd1, 1'b0, NO_RES},
		'{'{CMD_ADD, BASE_TIME + 16'd2, 16'd1, 8'd0}, 17'd1, 1'b0, NO_RES},
		// slot 2 arrives one tick late and preempts slot 1
		'{TICK_ITEM, 17'd3, 1'b0, NO_RES},
		'{'{CMD_ADD, BASE_TIME + 16'd4, 16'd2, 8'd7}, 17'd1, 1'b0, NO_RES},
		'{'{CMD_ADD, BASE_TIME + 16'd3, 16'd1, 8'd7}, 17'd1, 1'b0, NO_RES},
		'{'{CMD_ADD, BASE_TIME + 16'd3, 16'd1, 8'd7}, 17'd1, 1'b0, NO_RES},
		// equal priority: earlier arrival wins, then the lower slot
		'{TICK_ITEM, 17'd4, 1'b0, NO_RES},
		'{'{CMD_ADD, TIME_MAX, 16'hFFFF, 8'd255}, 17'd1, 1'b0, NO_RES},
		'{TICK_ITEM, 17'd1, 1'b0, NO_RES}	// idle although work is loaded
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [15:0] arrival_time;
	logic [15:0] burst_length;
	logic [7:0]  priority_level;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] time_after;
	logic        ran_valid;
	logic [3:0]  ran_slot;
	logic        finished;
	logic [15:0] completion_time;
	logic [15:0] turnaround;
	logic [15:0] waiting;
	logic        all_done;
	logic [31:0] total_turnaround;
	logic [31:0] total_waiting;

	// scheduler state as the bench sees it
	logic [15:0] tbl_arrival [SLOTS];
	logic [7:0]  tbl_prio    [SLOTS];
	logic [15:0] tbl_left    [SLOTS];
	logic [15:0] tbl_burst   [SLOTS];
	int          tasks_loaded;
	int          tasks_done;
	logic [15:0] sim_now;
	logic [31:0] sum_tat;
	logic [31:0] sum_wait;

	tick_result_t expected_ticks [$];
	int           mismatch_count;
	int           cycle_count;
	int           idle_pct;

	preemptive_priority_scheduler #(
		.TASK_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.arrival_time(arrival_time),
		.burst_length(burst_length),
		.priority_level(priority_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.time_after(time_after),
		.ran_valid(ran_valid),
		.ran_slot(ran_slot),
		.finished(finished),
		.completion_time(completion_time),
		.turnaround(turnaround),
		.waiting(waiting),
		.all_done(all_done),
		.total_turnaround(total_turnaround),
		.total_waiting(total_waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic schedule_item(input sched_item_t it, output bit has_res,
			output tick_result_t res);
		bit          found;
		int          best;
		logic [32:0] acc;
		has_res = 1'b0;
		res = '0;
		found = 1'b0;
		best = 0;
		if (it.cmd == CMD_ADD) begin
			if (tasks_loaded < SLOTS && it.burst != 16'd0) begin
				tbl_arrival[tasks_loaded] = it.arrival;
				tbl_prio[tasks_loaded] = it.prio;
				tbl_left[tasks_loaded] = it.burst;
				tbl_burst[tasks_loaded] = it.burst;
				tasks_loaded++;
			end
		end else begin
			for (int i = 0; i < tasks_loaded; i++) begin
				if (tbl_arrival[i] <= sim_now && tbl_left[i] != 16'd0 &&
						(!found || tbl_prio[i] < tbl_prio[best] ||
						(tbl_prio[i] == tbl_prio[best] &&
						tbl_arrival[i] < tbl_arrival[best]))) begin
					found = 1'b1;
					best = i;
				end
			end
			if (sim_now != TIME_MAX)
				sim_now++;
			has_res = 1'b1;
			if (found) begin
				res.ran = 1'b1;
				res.slot = 4'(best);
				tbl_left[best]--;
				if (tbl_left[best] == 16'd0) begin
					res.fin = 1'b1;
					res.ct = sim_now;
					res.tat = sim_now - tbl_arrival[best];
					// only after saturation can the turnaround fall below the burst
					res.wt = (res.tat >= tbl_burst[best]) ? res.tat - tbl_burst[best] : 16'd0;
					acc = {1'b0, sum_tat} + 33'(res.tat);
					sum_tat = acc[32] ? SUM_MAX : acc[31:0];
					acc = {1'b0, sum_wait} + 33'(res.wt);
					sum_wait = acc[32] ? SUM_MAX : acc[31:0];
					tasks_done++;
				end
			end
			res.t_after = sim_now;
			res.all_done = (tasks_done == tasks_loaded);
			res.tot_tat = sum_tat;
			res.tot_wt = sum_wait;
		end
	endtask

	task automatic drive_item(input sched_item_t it, input bit typed,
			input tick_result_t typed_res);
		bit           has_res;
		tick_result_t res;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		arrival_time <= it.arrival;
		burst_length <= it.burst;
		priority_level <= it.prio;
		do @(posedge clk); while (in_stall);
		schedule_item(it, has_res, res);
		if (has_res)
			expected_ticks.push_back(typed ? typed_res : res);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
				$time, name, want, got);
		end
	endtask

	task automatic check_result(input tick_result_t got);
		tick_result_t want;
		if (expected_ticks.size() == 0) begin
			mismatch_count++;
			$display("%0t ns: result with no tick pending, expected none, got time 0x%0h",
				$time, got.t_after);
		end else begin
			want = expected_ticks.pop_front();
			check_field("time_after", 32'(want.t_after), 32'(got.t_after));
			check_field("ran_valid", 32'(want.ran), 32'(got.ran));
			check_field("ran_slot", 32'(want.slot), 32'(got.slot));
			check_field("finished", 32'(want.fin), 32'(got.fin));
			check_field("completion_time", 32'(want.ct), 32'(got.ct));
			check_field("turnaround", 32'(want.tat), 32'(got.tat));
			check_field("waiting", 32'(want.wt), 32'(got.wt));
			check_field("all_done", 32'(want.all_done), 32'(got.all_done));
			check_field("total_turnaround", want.tot_tat, got.tot_tat);
			check_field("total_waiting", want.tot_wt, got.tot_wt);
		end
	endtask

	// result side
	initial begin
		tick_result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = '{time_after, ran_valid, ran_slot, finished, completion_time,
					turnaround, waiting, all_done, total_turnaround, total_waiting};
				check_result(got);
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		int unsigned hold;
		hold = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
				hold = $urandom_range(1, 15);
			if (hold != 0) begin
				out_stall <= 1'b1;
				hold--;
			end else
				out_stall <= 1'b0;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		sched_item_t it;
		int          issued;
		int          counted;
		int          remaining;
		int          free_slots;
		int          loaded_prev;
		int          roll;
		int          arr;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_ADD;
		arrival_time = 16'd0;
		burst_length = 16'd0;
		priority_level = 8'd0;
		idle_pct = 0;
		mismatch_count = 0;
		tasks_loaded = 0;
		tasks_done = 0;
		sim_now = 16'd0;
		sum_tat = 32'd0;
		sum_wait = 32'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_ROWS; r++) begin
			idle_pct = (DIR_ROWS[r].reps > 17'd1) ? 0 : 10;
			for (int k = 0; k < int'(DIR_ROWS[r].reps); k++)
				drive_item(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].want);
		end

		// random part; adds grow likelier as fewer items remain and are forced in the last 30 while slots are free
		issued = 0;
		counted = 0;
		while (counted < RAND_ITEMS) begin
			remaining = RAND_ITEMS - counted;
			if (remaining <= 80)
				idle_pct = 0;
			else if (issued % 48 == 0) begin
				case ($urandom_range(0, 3))
					0: idle_pct = 0;
					1: idle_pct = 5;
					2: idle_pct = 15;
					default: idle_pct = 30;
				endcase
			end
			if (issued == 150) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (expected_ticks.size() != 0);
			end
			free_slots = SLOTS - tasks_loaded;
			roll = int'($urandom_range(0, 99));
			if (free_slots != 0 && (remaining <= 30 ||
					int'($urandom_range(0, remaining)) <= free_slots)) begin
				arr = int'(sim_now) - 10 + int'($urandom_range(0, 50));
				if (arr < 0)
					arr = 0;
				if (arr > 65535)
					arr = 65535;
				it.cmd = CMD_ADD;
				it.arrival = 16'(arr);
				it.burst = 16'($urandom_range(1, 24));
				it.prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
			end else if (roll < 6) begin
				// noise: dropped for zero burst or a full table
				it.cmd = CMD_ADD;
				it.arrival = 16'($urandom);
				it.burst = (free_slots != 0 || roll < 3) ? 16'd0 : 16'($urandom);
				it.prio = 8'($urandom);
			end else begin
				it.cmd = CMD_TICK;
				it.arrival = 16'($urandom);
				it.burst = 16'($urandom);
				it.prio = 8'($urandom);
			end
			loaded_prev = tasks_loaded;
			drive_item(it, 1'b0, NO_RES);
			if (it.cmd == CMD_TICK || tasks_loaded != loaded_prev)
				counted++;
			issued++;
		end

		in_valid <= 1'b0;
		idle_pct = 0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
		if (mismatch_count == 0 && expected_ticks.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
